[sv/bank_switch_memory_mapper_core_assert.svh]
// Assertion macros for the mapper core.
`ifndef BANK_SWITCH_MEMORY_MAPPER_CORE_ASSERT_SVH
`define BANK_SWITCH_MEMORY_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mapper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mapper assertion failed");

`endif

[sv/bsm_pkg.sv]
package bsm_pkg;

    // Input item: one CPU access
    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    // Result item
    typedef struct packed {
        logic [1:0]  target;
        logic [21:0] offset;
        logic        save_used;
    } rsp_t;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Target codes
    localparam logic [1:0] TGT_ROM  = 2'd0;
    localparam logic [1:0] TGT_WRAM = 2'd1;
    localparam logic [1:0] TGT_SRAM = 2'd2;
    localparam logic [1:0] TGT_DROP = 2'd3;

    // Address map constants
    localparam logic [15:0] FC_BASE_ADDR  = 16'hFFFC;
    localparam logic [2:0]  SLOT_SRAM_LO  = 3'd4;
    localparam logic [2:0]  SLOT_WRAM_LO  = 3'd6;
    localparam int unsigned FC0_SRAM_EN   = 3;
    localparam int unsigned FC0_SRAM_BANK = 2;

    // Frame-control reset values
    localparam logic [7:0] FC0_RST = 8'h00;
    localparam logic [7:0] FC1_RST = 8'h00;
    localparam logic [7:0] FC2_RST = 8'h01;
    localparam logic [7:0] FC3_RST = 8'h00;

    // Page-count register width and reset
    localparam int unsigned PAGES_W   = 9;
    localparam logic [8:0]  PAGES_RST = 9'd1;

    // Remainder bits retired per divider step
    localparam int unsigned DIV_BITS_PER_STEP = 4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch the access, start the page remainder
        logic step;    // one remainder step
        logic commit;  // form result, update mapper registers
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage

[sv/bsm_ctrl.sv]
module bsm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bsm_pkg::dp_status_t status,
    output bsm_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV0,
        S_DIV1,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV0;
                end
            end
            S_DIV0:
            begin
                cmd.step   = 1'b1;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.step   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/bsm_datapath.sv]
module bsm_datapath #(
    parameter int unsigned MAX_ROM_PAGES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bsm_pkg::req_t       req,
    input  logic                cfg_wr_en,
    input  logic [8:0]          cfg_wr_data,
    input  bsm_pkg::dp_cmd_t    cmd,
    output bsm_pkg::dp_status_t status,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bsm_pkg::rsp_t       rsp
);

    // Mapper state
    logic [7:0]  fc_reg [4];
    logic        save_flag_reg;
    logic        save_flag_next;
    logic [8:0]  rom_pages_reg;

    // Access and remainder unit
    bsm_pkg::req_t req_reg;
    logic [7:0]    dvd_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    rem_next;
    logic [7:0]    dvd_next;
    logic [7:0]    dvd_load;
    logic [8:0]    divisor;

    // Output register
    logic          rsp_valid_reg;
    bsm_pkg::rsp_t rsp_reg;
    bsm_pkg::rsp_t rsp_next;

    // Effective page count, clamped to 1..MAX_ROM_PAGES
    always_comb
    begin
        if (rom_pages_reg == '0)
        begin
            divisor = 9'd1;
        end
        else if (rom_pages_reg > 9'(MAX_ROM_PAGES))
        begin
            divisor = 9'(MAX_ROM_PAGES);
        end
        else
        begin
            divisor = rom_pages_reg;
        end
    end

    // Page register picked by the slot pair of the incoming access
    always_comb
    begin
        case (req.address[15:14])
            2'd0:    dvd_load = fc_reg[1];
            2'd1:    dvd_load = fc_reg[2];
            2'd2:    dvd_load = fc_reg[3];
            default: dvd_load = '0;
        endcase
    end

    // Restoring remainder, DIV_BITS_PER_STEP dividend bits per step
    always_comb
    begin
        logic [8:0] r;
        logic [7:0] d;
        r = {1'b0, rem_reg};
        d = dvd_reg;
        for (int i = 0; i < int'(bsm_pkg::DIV_BITS_PER_STEP); i++)
        begin
            r = {r[7:0], d[7]};
            d = {d[6:0], 1'b0};
            if (r >= divisor)
            begin
                r = r - divisor;
            end
        end
        rem_next = r[7:0];
        dvd_next = d;
    end

    // Result of the latched access
    always_comb
    begin
        logic [2:0]  slot;
        logic [12:0] low;
        logic        half;
        slot = req_reg.address[15:13];
        low  = req_reg.address[12:0];
        half = req_reg.address[13];

        // sticky save flag as it stands after this access
        save_flag_next = save_flag_reg;
        if (req_reg.cmd == bsm_pkg::CMD_WRITE && req_reg.address >= bsm_pkg::FC_BASE_ADDR
            && req_reg.address[1:0] == 2'd0
            && req_reg.write_data[bsm_pkg::FC0_SRAM_EN])
        begin
            save_flag_next = 1'b1;
        end

        rsp_next.save_used = save_flag_next;
        if (slot >= bsm_pkg::SLOT_WRAM_LO)
        begin
            rsp_next.target = bsm_pkg::TGT_WRAM;
            rsp_next.offset = {9'd0, low};
        end
        else if (slot >= bsm_pkg::SLOT_SRAM_LO && fc_reg[0][bsm_pkg::FC0_SRAM_EN])
        begin
            rsp_next.target = bsm_pkg::TGT_SRAM;
            rsp_next.offset = {7'd0, fc_reg[0][bsm_pkg::FC0_SRAM_BANK], half, low};
        end
        else if (req_reg.cmd == bsm_pkg::CMD_WRITE)
        begin
            rsp_next.target = bsm_pkg::TGT_DROP;
            rsp_next.offset = '0;
        end
        else
        begin
            rsp_next.target = bsm_pkg::TGT_ROM;
            rsp_next.offset = {rem_reg, half, low};
        end
    end

    assign status.out_free = !rsp_valid_reg || !rsp_stall;

    // Access latch and remainder registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            dvd_reg <= dvd_load;
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    // Mapper registers and page count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg[0]     <= bsm_pkg::FC0_RST;
            fc_reg[1]     <= bsm_pkg::FC1_RST;
            fc_reg[2]     <= bsm_pkg::FC2_RST;
            fc_reg[3]     <= bsm_pkg::FC3_RST;
            save_flag_reg <= 1'b0;
            rom_pages_reg <= bsm_pkg::PAGES_RST;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rom_pages_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                save_flag_reg <= save_flag_next;
                if (req_reg.cmd == bsm_pkg::CMD_WRITE
                    && req_reg.address >= bsm_pkg::FC_BASE_ADDR)
                begin
                    fc_reg[req_reg.address[1:0]] <= req_reg.write_data;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[sv/bank_switch_memory_mapper_core.sv]
// Each accept latches the access, runs two remainder steps, then commits once the output register has room.
// One access at a time; the shared remainder unit (4 page bits a step) holds req_stall until commit.
// A result waits in the output register without blocking the next accept.
// Reset (rst_n, async, active low): frame control 0,0,1,0, save flag clear,
// page count 1, no result pending.
module bank_switch_memory_mapper_core #(
    parameter int unsigned MAX_ROM_PAGES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bsm_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bsm_pkg::rsp_t   rsp,
    input  logic            cfg_wr_en,
    input  logic [8:0]      cfg_wr_data
);

    bsm_pkg::dp_cmd_t    cmd;
    bsm_pkg::dp_status_t status;

    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bsm_datapath #(
        .MAX_ROM_PAGES (MAX_ROM_PAGES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

`include "bank_switch_memory_mapper_core_assert.svh"

    // One access at a time: busy right after an accept
    `BSM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

    // Discarded writes carry a zero offset
    `BSM_ASSERT_NOW(a_drop_zero_offset, clk, rst_n, rsp_valid && rsp.target == bsm_pkg::TGT_DROP, rsp.offset == '0)

    // Save flag never clears once reported
    `BSM_ASSERT_NEXT(a_save_sticky, clk, rst_n, rsp_valid && rsp.save_used, !rsp_valid || rsp.save_used)

    // A commit always raises rsp_valid
    `BSM_ASSERT_NEXT(a_commit_room, clk, rst_n, cmd.commit, rsp_valid)

endmodule
